/* hdl/tmu_pkg.sv */
// ----------------------------------------------------------------------------
// tmu_pkg
// Shared constants, register codes and types of the mode unfold index unit.
// ----------------------------------------------------------------------------
package tmu_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_MODES  = 6;
    localparam int DEF_COORD_BITS = 10;

    // Fixed field widths.
    localparam int NUM_DIM_REGS = 6;
    localparam int DIM_W        = 10;
    localparam int MODE_W       = 3;
    localparam int ROW_W        = 10;
    localparam int COL_W        = 50;
    localparam int PAYLOAD_W    = 64;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register reset values.
    localparam logic [MODE_W-1:0] RST_NUM_MODES   = 3'd3;
    localparam logic [MODE_W-1:0] RST_UNFOLD_MODE = 3'd0;
    localparam logic [DIM_W-1:0]  RST_DIM         = 10'd1;

    // Register index, from the byte address divided by four.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_MODES   = 3'd0,
        REG_UNFOLD_MODE = 3'd1,
        REG_DIM_0       = 3'd2,
        REG_DIM_1       = 3'd3,
        REG_DIM_2       = 3'd4,
        REG_DIM_3       = 3'd5,
        REG_DIM_4       = 3'd6,
        REG_DIM_5       = 3'd7
    } reg_idx_t;

    // Role of one mode for the current configuration.
    typedef struct packed {
        logic used;    // mode index is below the effective mode count
        logic unfold;  // mode is the one the tensor is unfolded along
    } mode_ctl_t;

endpackage

/* hdl/tmu_stride_seq.sv */
// ----------------------------------------------------------------------------
// tmu_stride_seq
// Recomputes the column stride of every mode, one mode per cycle, after a
// register write.
// ----------------------------------------------------------------------------
module tmu_stride_seq #(
    parameter int MAX_MODES  = tmu_pkg::DEF_MAX_MODES,
    parameter int COORD_BITS = tmu_pkg::DEF_COORD_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [tmu_pkg::MODE_W-1:0]             unfold_mode,
    input  logic [COORD_BITS-1:0]                  dim_eff [MAX_MODES],
    output logic [tmu_pkg::COL_W-1:0]              stride [MAX_MODES],
    output logic                                   busy
);

    localparam int CNT_W = $clog2(MAX_MODES);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_MODES - 1);

    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic [tmu_pkg::COL_W-1:0] product_reg;
    logic [tmu_pkg::COL_W-1:0] stride_reg [MAX_MODES];
    logic [tmu_pkg::COL_W-1:0] product_next;

    // The running product skips the unfold mode.
    always_comb begin
        product_next = product_reg;
        if (unfold_mode != tmu_pkg::MODE_W'(cnt_reg)) begin
            product_next = product_reg * tmu_pkg::COL_W'(dim_eff[cnt_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            product_reg <= tmu_pkg::COL_W'(1);
            for (int k = 0; k < MAX_MODES; k++) begin
                stride_reg[k] <= tmu_pkg::COL_W'(1);
            end
        end else if (start) begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b1;
            product_reg <= tmu_pkg::COL_W'(1);
        end else if (busy_reg) begin
            stride_reg[cnt_reg] <= product_reg;
            product_reg         <= product_next;
            cnt_reg             <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stride = stride_reg;
    assign busy   = busy_reg;

endmodule

/* hdl/tmu_cell.sv */
// ----------------------------------------------------------------------------
// tmu_cell
// One mode of the index chain: checks its coordinate, adds its column term
// or takes the row, and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module tmu_cell #(
    parameter int INDEX      = 0,
    parameter int MAX_MODES  = tmu_pkg::DEF_MAX_MODES,
    parameter int COORD_BITS = tmu_pkg::DEF_COORD_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tmu_pkg::mode_ctl_t                   ctl,
    input  logic [COORD_BITS-1:0]                dim,
    input  logic [tmu_pkg::COL_W-1:0]            stride,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [MAX_MODES*COORD_BITS-1:0]      in_coords,
    input  logic [tmu_pkg::PAYLOAD_W-1:0]        in_payload,
    input  logic [COORD_BITS-1:0]                in_row,
    input  logic [tmu_pkg::COL_W-1:0]            in_col,
    input  logic                                 in_bad,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [MAX_MODES*COORD_BITS-1:0]      out_coords,
    output logic [tmu_pkg::PAYLOAD_W-1:0]        out_payload,
    output logic [COORD_BITS-1:0]                out_row,
    output logic [tmu_pkg::COL_W-1:0]            out_col,
    output logic                                 out_bad
);

    logic                                valid_reg;
    logic [MAX_MODES*COORD_BITS-1:0]     coords_reg;
    logic [tmu_pkg::PAYLOAD_W-1:0]       payload_reg;
    logic [COORD_BITS-1:0]               row_reg;
    logic [tmu_pkg::COL_W-1:0]           col_reg;
    logic                                bad_reg;

    logic [COORD_BITS-1:0]               coord;
    logic                                bad_here;
    logic [tmu_pkg::COL_W-1:0]           term;
    logic [COORD_BITS-1:0]               row_next;
    logic [tmu_pkg::COL_W-1:0]           col_next;

    assign coord    = in_coords[INDEX*COORD_BITS +: COORD_BITS];
    assign bad_here = ctl.used && ((coord == '0) || (coord > dim));
    assign term     = tmu_pkg::COL_W'(coord - 1'b1) * stride;

    always_comb begin
        row_next = in_row;
        col_next = in_col;
        if (ctl.used && !bad_here) begin
            if (ctl.unfold) begin
                row_next = coord;
            end else begin
                col_next = in_col + term;
            end
        end
    end

    // A held word moves on as soon as the next cell can take it.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            coords_reg  <= in_coords;
            payload_reg <= in_payload;
            row_reg     <= row_next;
            col_reg     <= col_next;
            bad_reg     <= in_bad || bad_here;
        end
    end

    assign out_valid   = valid_reg;
    assign out_coords  = coords_reg;
    assign out_payload = payload_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign out_bad     = bad_reg;

endmodule

/* hdl/tensor_mode_unfold_index_unit.sv */
// ----------------------------------------------------------------------------
// tensor_mode_unfold_index_unit
// Maps the coordinates of one sparse tensor nonzero to its row and column in
// the mode-n unfolded matrix, passing the value payload through.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle and returns one word per cycle while
// s_ready and m_ready are high. Each word runs through a chain of MAX_MODES
// cells, one per mode, and every cell holds one word; a word is registered in
// each cell in turn before it reaches the result channel. A stalled output
// stops only the cells behind it. After any register write the strides are
// rebuilt by a sequencer that visits one mode per cycle, and s_ready stays low
// in the write's access cycle and while the sequencer is busy. A coordinate of
// zero or above its mode size in a mode in use, or an unfold mode at or beyond
// the mode count, sets m_bad_coord and returns zero for both indices.
module tensor_mode_unfold_index_unit #(
    parameter int MAX_MODES  = tmu_pkg::DEF_MAX_MODES,
    parameter int COORD_BITS = tmu_pkg::DEF_COORD_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmu_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tmu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tmu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [COORD_BITS-1:0]               s_coord_0,
    input  logic [COORD_BITS-1:0]               s_coord_1,
    input  logic [COORD_BITS-1:0]               s_coord_2,
    input  logic [COORD_BITS-1:0]               s_coord_3,
    input  logic [COORD_BITS-1:0]               s_coord_4,
    input  logic [COORD_BITS-1:0]               s_coord_5,
    input  logic [tmu_pkg::PAYLOAD_W-1:0]       s_payload,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmu_pkg::ROW_W-1:0]           m_row_index,
    output logic [tmu_pkg::COL_W-1:0]           m_column_index,
    output logic [tmu_pkg::PAYLOAD_W-1:0]       m_payload_out,
    output logic                                m_bad_coord
);

    localparam int VEC_W = MAX_MODES * COORD_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [tmu_pkg::MODE_W-1:0]  num_modes_reg;
    logic [tmu_pkg::MODE_W-1:0]  unfold_mode_reg;
    logic [tmu_pkg::DIM_W-1:0]   dim_reg [tmu_pkg::NUM_DIM_REGS];

    logic                        cfg_wr;
    tmu_pkg::reg_idx_t           reg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = tmu_pkg::reg_idx_t'(paddr[tmu_pkg::APB_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_modes_reg   <= tmu_pkg::RST_NUM_MODES;
            unfold_mode_reg <= tmu_pkg::RST_UNFOLD_MODE;
            for (int k = 0; k < tmu_pkg::NUM_DIM_REGS; k++) begin
                dim_reg[k] <= tmu_pkg::RST_DIM;
            end
        end else if (cfg_wr) begin
            case (reg_idx)
                tmu_pkg::REG_NUM_MODES:   num_modes_reg   <= pwdata[tmu_pkg::MODE_W-1:0];
                tmu_pkg::REG_UNFOLD_MODE: unfold_mode_reg <= pwdata[tmu_pkg::MODE_W-1:0];
                tmu_pkg::REG_DIM_0:       dim_reg[0]      <= pwdata[tmu_pkg::DIM_W-1:0];
                tmu_pkg::REG_DIM_1:       dim_reg[1]      <= pwdata[tmu_pkg::DIM_W-1:0];
                tmu_pkg::REG_DIM_2:       dim_reg[2]      <= pwdata[tmu_pkg::DIM_W-1:0];
                tmu_pkg::REG_DIM_3:       dim_reg[3]      <= pwdata[tmu_pkg::DIM_W-1:0];
                tmu_pkg::REG_DIM_4:       dim_reg[4]      <= pwdata[tmu_pkg::DIM_W-1:0];
                tmu_pkg::REG_DIM_5:       dim_reg[5]      <= pwdata[tmu_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tmu_pkg::REG_NUM_MODES:   prdata = tmu_pkg::APB_DATA_W'(num_modes_reg);
            tmu_pkg::REG_UNFOLD_MODE: prdata = tmu_pkg::APB_DATA_W'(unfold_mode_reg);
            tmu_pkg::REG_DIM_0:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[0]);
            tmu_pkg::REG_DIM_1:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[1]);
            tmu_pkg::REG_DIM_2:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[2]);
            tmu_pkg::REG_DIM_3:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[3]);
            tmu_pkg::REG_DIM_4:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[4]);
            tmu_pkg::REG_DIM_5:       prdata = tmu_pkg::APB_DATA_W'(dim_reg[5]);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Mode roles and strides
    // ------------------------------------------------------------------
    logic [tmu_pkg::MODE_W-1:0]  modes_eff;
    logic                        unfold_bad;
    logic [COORD_BITS-1:0]       dim_eff [MAX_MODES];
    logic [tmu_pkg::COL_W-1:0]   stride [MAX_MODES];
    tmu_pkg::mode_ctl_t          mode_ctl [MAX_MODES];
    logic                        stride_busy;

    assign modes_eff  = (num_modes_reg > tmu_pkg::MODE_W'(MAX_MODES)) ?
                        tmu_pkg::MODE_W'(MAX_MODES) : num_modes_reg;
    assign unfold_bad = unfold_mode_reg >= modes_eff;

    for (genvar k = 0; k < MAX_MODES; k++) begin : g_mode
        assign dim_eff[k]         = COORD_BITS'(dim_reg[k]);
        assign mode_ctl[k].used   = tmu_pkg::MODE_W'(k) < modes_eff;
        assign mode_ctl[k].unfold = unfold_mode_reg == tmu_pkg::MODE_W'(k);
    end

    tmu_stride_seq #(
        .MAX_MODES  (MAX_MODES),
        .COORD_BITS (COORD_BITS)
    ) u_stride_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cfg_wr),
        .unfold_mode (unfold_mode_reg),
        .dim_eff     (dim_eff),
        .stride      (stride),
        .busy        (stride_busy)
    );

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]          coord_all [tmu_pkg::NUM_DIM_REGS];
    logic                           c_valid   [MAX_MODES+1];
    logic                           c_ready   [MAX_MODES+1];
    logic [VEC_W-1:0]               c_coords  [MAX_MODES+1];
    logic [tmu_pkg::PAYLOAD_W-1:0]  c_payload [MAX_MODES+1];
    logic [COORD_BITS-1:0]          c_row     [MAX_MODES+1];
    logic [tmu_pkg::COL_W-1:0]      c_col     [MAX_MODES+1];
    logic                           c_bad     [MAX_MODES+1];
    logic                           in_open;

    assign coord_all[0] = s_coord_0;
    assign coord_all[1] = s_coord_1;
    assign coord_all[2] = s_coord_2;
    assign coord_all[3] = s_coord_3;
    assign coord_all[4] = s_coord_4;
    assign coord_all[5] = s_coord_5;

    for (genvar k = 0; k < MAX_MODES; k++) begin : g_coord
        assign c_coords[0][k*COORD_BITS +: COORD_BITS] = coord_all[k];
    end

    // No word enters while the strides are being rebuilt.
    assign in_open      = !stride_busy && !cfg_wr;
    assign c_valid[0]   = s_valid && in_open;
    assign s_ready      = c_ready[0] && in_open;
    assign c_payload[0] = s_payload;
    assign c_row[0]     = '0;
    assign c_col[0]     = tmu_pkg::COL_W'(1);
    assign c_bad[0]     = unfold_bad;

    for (genvar k = 0; k < MAX_MODES; k++) begin : g_cell
        tmu_cell #(
            .INDEX      (k),
            .MAX_MODES  (MAX_MODES),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (mode_ctl[k]),
            .dim         (dim_eff[k]),
            .stride      (stride[k]),
            .in_valid    (c_valid[k]),
            .in_ready    (c_ready[k]),
            .in_coords   (c_coords[k]),
            .in_payload  (c_payload[k]),
            .in_row      (c_row[k]),
            .in_col      (c_col[k]),
            .in_bad      (c_bad[k]),
            .out_valid   (c_valid[k+1]),
            .out_ready   (c_ready[k+1]),
            .out_coords  (c_coords[k+1]),
            .out_payload (c_payload[k+1]),
            .out_row     (c_row[k+1]),
            .out_col     (c_col[k+1]),
            .out_bad     (c_bad[k+1])
        );
    end

    assign c_ready[MAX_MODES] = m_ready;
    assign m_valid            = c_valid[MAX_MODES];
    assign m_bad_coord        = c_bad[MAX_MODES];
    assign m_payload_out      = c_payload[MAX_MODES];
    assign m_row_index        = c_bad[MAX_MODES] ? '0 :
                                tmu_pkg::ROW_W'(c_row[MAX_MODES]);
    assign m_column_index     = c_bad[MAX_MODES] ? '0 : c_col[MAX_MODES];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_busy : assert property (
        @(posedge aclk) disable iff (!aresetn)
        stride_busy |-> !s_ready
    ) else $error("input word accepted while strides are rebuilt");

    a_write_starts_rebuild : assert property (
        @(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> stride_busy
    ) else $error("register write did not start a stride rebuild");

    a_bad_unfold_flags : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && unfold_bad) |=> c_bad[1]
    ) else $error("unfold mode out of range not flagged in first cell");

endmodule

/* tb/tb_tensor_mode_unfold_index_unit.sv */
// ----------------------------------------------------------------------------
// tb_tensor_mode_unfold_index_unit
// Self-checking bench for the mode-n unfold index unit. Shapes are written
// through the register port and read back. Coordinate words are then streamed
// in with bursty timing while the result side stalls on its own pattern. A
// shadow copy of the shape and of the column strides predicts row, column,
// payload and error flag for every word, and each returned word is compared
// in order. Directed words cover the range limits and error cases. A
// backpressure test then holds the output off long enough to back the unit up
// to its input, and random phases follow with a fresh shape each.
// ----------------------------------------------------------------------------
module tb_tensor_mode_unfold_index_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODES       = tmu_pkg::DEF_MAX_MODES;
    localparam int CBITS       = tmu_pkg::DEF_COORD_BITS;
    localparam int HOLD_OFF    = 300;
    localparam int STUCK_LIMIT = 4000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 60;

    typedef logic [MODES-1:0][CBITS-1:0] coord_set_t;

    typedef struct packed {
        logic [tmu_pkg::ROW_W-1:0]     row;
        logic [tmu_pkg::COL_W-1:0]     col;
        logic [tmu_pkg::PAYLOAD_W-1:0] payload;
        logic                          bad;
    } matrix_entry_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [tmu_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [tmu_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [tmu_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [CBITS-1:0]               s_coord_0 = '0;
    logic [CBITS-1:0]               s_coord_1 = '0;
    logic [CBITS-1:0]               s_coord_2 = '0;
    logic [CBITS-1:0]               s_coord_3 = '0;
    logic [CBITS-1:0]               s_coord_4 = '0;
    logic [CBITS-1:0]               s_coord_5 = '0;
    logic [tmu_pkg::PAYLOAD_W-1:0]  s_payload = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [tmu_pkg::ROW_W-1:0]      m_row_index;
    logic [tmu_pkg::COL_W-1:0]      m_column_index;
    logic [tmu_pkg::PAYLOAD_W-1:0]  m_payload_out;
    logic                           m_bad_coord;

    // Shadow of the register file and the strides derived from it.
    logic [tmu_pkg::MODE_W-1:0] shape_modes;
    logic [tmu_pkg::MODE_W-1:0] shape_unfold;
    logic [tmu_pkg::DIM_W-1:0]  shape_dim [tmu_pkg::NUM_DIM_REGS];
    logic [tmu_pkg::COL_W-1:0]  mode_stride [MODES];

    matrix_entry_t expected_entries [$];
    int            mismatches      = 0;
    int            stuck_cycles    = 0;
    bit            src_gaps_on     = 1'b1;
    int            burst_left      = 0;
    bit            sink_stalls_on  = 1'b1;
    int            hold_off_cycles = 0;

    tensor_mode_unfold_index_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coord_0      (s_coord_0),
        .s_coord_1      (s_coord_1),
        .s_coord_2      (s_coord_2),
        .s_coord_3      (s_coord_3),
        .s_coord_4      (s_coord_4),
        .s_coord_5      (s_coord_5),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_index    (m_row_index),
        .m_column_index (m_column_index),
        .m_payload_out  (m_payload_out),
        .m_bad_coord    (m_bad_coord)
    );

    always #4 aclk = ~aclk;

    // Each stride is the product of the sizes of all lower modes except the
    // unfold mode, kept to the column width.
    function automatic void rebuild_strides();
        logic [tmu_pkg::COL_W-1:0] running;
        running = tmu_pkg::COL_W'(1);
        for (int k = 0; k < MODES; k++) begin
            mode_stride[k] = running;
            if (k != shape_unfold) running = running * tmu_pkg::COL_W'(shape_dim[k]);
        end
    endfunction

    function automatic matrix_entry_t unfold_entry(
        input coord_set_t c,
        input logic [tmu_pkg::PAYLOAD_W-1:0] value
    );
        matrix_entry_t             e;
        int                        used;
        logic                      bad;
        logic [tmu_pkg::ROW_W-1:0] row;
        logic [tmu_pkg::COL_W-1:0] col;
        used = (shape_modes > MODES) ? MODES : int'(shape_modes);
        bad  = (shape_unfold >= used);
        row  = '0;
        col  = tmu_pkg::COL_W'(1);
        for (int k = 0; k < used; k++) begin
            if (c[k] == '0 || c[k] > shape_dim[k]) begin
                bad = 1'b1;
            end else if (k == shape_unfold) begin
                row = tmu_pkg::ROW_W'(c[k]);
            end else begin
                col = col + tmu_pkg::COL_W'(c[k] - 1'b1) * mode_stride[k];
            end
        end
        e.row     = bad ? '0 : row;
        e.col     = bad ? '0 : col;
        e.payload = value;
        e.bad     = bad;
        return e;
    endfunction

    function automatic coord_set_t make_coords(input int c0, c1, c2, c3, c4, c5);
        coord_set_t c;
        c[0] = CBITS'(c0);
        c[1] = CBITS'(c1);
        c[2] = CBITS'(c2);
        c[3] = CBITS'(c3);
        c[4] = CBITS'(c4);
        c[5] = CBITS'(c5);
        return c;
    endfunction

    function automatic logic [tmu_pkg::PAYLOAD_W-1:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // Sends one coordinate word; the sender may idle between bursts when gaps are on.
    task automatic offer_nonzero(input coord_set_t c,
                                 input logic [tmu_pkg::PAYLOAD_W-1:0] value);
        int gap;
        if (src_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(12, 1);
                gap        = $urandom_range(6, 0);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid   <= 1'b1;
        s_coord_0 <= c[0];
        s_coord_1 <= c[1];
        s_coord_2 <= c[2];
        s_coord_3 <= c[3];
        s_coord_4 <= c[4];
        s_coord_5 <= c[5];
        s_payload <= value;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        expected_entries.push_back(unfold_entry(c, value));
    endtask

    // Drops valid and waits until every word sent has come back.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_entries.size() != 0);
    endtask

    task automatic apb_access(input logic is_write, input tmu_pkg::reg_idx_t idx,
                              input logic [tmu_pkg::APB_DATA_W-1:0] wdata,
                              output logic [tmu_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        rdata = prdata;
        @(posedge aclk);
    endtask

    // Writes every register once, then reads all of them back.
    task automatic apply_shape(input int modes, unfold, d0, d1, d2, d3, d4, d5);
        int                             word [8];
        tmu_pkg::reg_idx_t              idx;
        logic [tmu_pkg::APB_DATA_W-1:0] readback;
        logic [tmu_pkg::APB_DATA_W-1:0] shadow;
        word = '{modes, unfold, d0, d1, d2, d3, d4, d5};
        settle();
        for (int i = 0; i < 8; i++) begin
            idx = tmu_pkg::reg_idx_t'(i);
            apb_access(1'b1, idx, word[i], readback);
            case (idx)
                tmu_pkg::REG_NUM_MODES:   shape_modes  = tmu_pkg::MODE_W'(word[i]);
                tmu_pkg::REG_UNFOLD_MODE: shape_unfold = tmu_pkg::MODE_W'(word[i]);
                default: shape_dim[i - tmu_pkg::REG_DIM_0] = tmu_pkg::DIM_W'(word[i]);
            endcase
            rebuild_strides();
        end
        for (int i = 0; i < 8; i++) begin
            idx = tmu_pkg::reg_idx_t'(i);
            apb_access(1'b0, idx, '0, readback);
            case (idx)
                tmu_pkg::REG_NUM_MODES:   shadow = tmu_pkg::APB_DATA_W'(shape_modes);
                tmu_pkg::REG_UNFOLD_MODE: shadow = tmu_pkg::APB_DATA_W'(shape_unfold);
                default: shadow = tmu_pkg::APB_DATA_W'(shape_dim[i - tmu_pkg::REG_DIM_0]);
            endcase
            if (readback !== shadow) begin
                mismatches++;
                $display("%0t: register %s expected %0d, got %0d",
                         $time, idx.name(), shadow, readback);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // Every size is 1 after reset and three modes are in use, so only words with ones in modes 0 to 2 fit.
        offer_nonzero(make_coords(1, 1, 1, 0, 1023, 517), '0);
        offer_nonzero(make_coords(1, 2, 1, 1, 1, 1), '1);
        offer_nonzero(make_coords(0, 1, 1, 1, 1, 1), wide_random());
        settle();
    endtask

    task automatic test_coordinate_extremes();
        apply_shape(6, 5, 1023, 1023, 1023, 1023, 1023, 1023);
        offer_nonzero(make_coords(1, 1, 1, 1, 1, 1), '0);
        offer_nonzero(make_coords(1023, 1023, 1023, 1023, 1023, 1023), '1);
        offer_nonzero(make_coords(1023, 1, 512, 1, 1023, 700), wide_random());
        offer_nonzero(make_coords(5, 5, 5, 0, 5, 5), wide_random());
        apply_shape(6, 0, 5, 1, 1022, 2, 9, 3);
        offer_nonzero(make_coords(5, 1, 1022, 2, 9, 3), wide_random());
        offer_nonzero(make_coords(5, 1, 1023, 2, 9, 3), wide_random());
        offer_nonzero(make_coords(5, 1, 1, 2, 10, 3), wide_random());
        offer_nonzero(make_coords(6, 1, 1, 1, 1, 1), wide_random());
        settle();
    endtask

    task automatic test_mode_count_limits();
        // No mode in use means the unfold mode can never be valid.
        apply_shape(0, 0, 4, 4, 4, 4, 4, 4);
        offer_nonzero(make_coords(1, 1, 1, 1, 1, 1), wide_random());
        // A count of seven behaves as six, so mode 5 is still checked.
        apply_shape(7, 3, 4, 4, 4, 4, 4, 4);
        offer_nonzero(make_coords(2, 3, 4, 1, 2, 3), wide_random());
        offer_nonzero(make_coords(2, 3, 4, 1, 2, 5), wide_random());
        apply_shape(1, 0, 9, 1, 1, 1, 1, 1);
        offer_nonzero(make_coords(9, 1023, 0, 7, 7, 7), wide_random());
        offer_nonzero(make_coords(10, 1, 1, 1, 1, 1), wide_random());
        settle();
    endtask

    task automatic test_unfold_out_of_range();
        apply_shape(3, 3, 8, 8, 8, 8, 8, 8);
        offer_nonzero(make_coords(1, 2, 3, 1, 1, 1), wide_random());
        apply_shape(3, 7, 8, 8, 8, 8, 8, 8);
        offer_nonzero(make_coords(4, 5, 6, 1, 1, 1), wide_random());
        apply_shape(7, 6, 8, 8, 8, 8, 8, 8);
        offer_nonzero(make_coords(1, 1, 1, 1, 1, 1), wide_random());
        settle();
    endtask

    task automatic test_zero_size();
        apply_shape(4, 1, 3, 4, 0, 2, 1, 1);
        offer_nonzero(make_coords(1, 1, 1, 1, 1, 1), wide_random());
        offer_nonzero(make_coords(1, 1, 0, 1, 1, 1), wide_random());
        // A zero size on a mode out of use does no harm.
        apply_shape(2, 1, 3, 4, 0, 2, 1, 1);
        offer_nonzero(make_coords(2, 3, 1, 1, 1, 1), wide_random());
        settle();
    endtask

    task automatic test_random_traffic();
        int         modes;
        int         used;
        int         unfold;
        int         kind;
        int         pick;
        int         k;
        int         d [tmu_pkg::NUM_DIM_REGS];
        coord_set_t c;
        for (int phase = 0; phase < PHASES; phase++) begin
            for (int m = 0; m < tmu_pkg::NUM_DIM_REGS; m++) begin
                pick = $urandom_range(19, 0);
                if (pick == 0)      d[m] = 0;
                else if (pick < 5)  d[m] = 1023;
                else if (pick < 10) d[m] = $urandom_range(8, 1);
                else                d[m] = $urandom_range(1023, 1);
            end
            modes = $urandom_range(6, 2);
            if (phase == 0) begin
                // Full-size shape so every coordinate bit gets exercised.
                modes = 6;
                for (int m = 0; m < tmu_pkg::NUM_DIM_REGS; m++) d[m] = 1023;
            end else if (phase == 1) begin
                modes = 1;
            end else if ($urandom_range(7, 0) == 0) begin
                modes = $urandom_range(1, 0) ? 0 : 7;
            end
            used   = (modes > MODES) ? MODES : modes;
            unfold = (used == 0) ? 0 : $urandom_range(used - 1, 0);
            if (phase > 1 && $urandom_range(9, 0) == 0) unfold = $urandom_range(7, 0);
            apply_shape(modes, unfold, d[0], d[1], d[2], d[3], d[4], d[5]);
            src_gaps_on    = (phase % 3 != 2);
            sink_stalls_on = (phase % 4 != 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                kind = $urandom_range(99, 0);
                for (int m = 0; m < MODES; m++) begin
                    c[m] = (d[m] == 0) ? '0 : CBITS'($urandom_range(d[m], 1));
                end
                if (kind >= 95) begin
                    for (int m = 0; m < MODES; m++) c[m] = CBITS'($urandom_range(1023, 0));
                end else if (kind >= 85) begin
                    // Break one coordinate of a mode in use, or of mode 0 when none is in use.
                    k = (used == 0) ? 0 : $urandom_range(used - 1, 0);
                    if ($urandom_range(1, 0) || d[k] >= 1023) c[k] = '0;
                    else c[k] = CBITS'($urandom_range(1023, d[k] + 1));
                end
                offer_nonzero(c, wide_random());
            end
        end
        settle();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        coord_set_t c;
        int         d [tmu_pkg::NUM_DIM_REGS];
        d = '{7, 300, 12, 1023, 1, 1};
        apply_shape(4, 2, d[0], d[1], d[2], d[3], d[4], d[5]);
        src_gaps_on     = 1'b0;
        hold_off_cycles = HOLD_OFF;
        for (int n = 0; n < 40; n++) begin
            for (int m = 0; m < MODES; m++) c[m] = CBITS'($urandom_range(d[m], 1));
            offer_nonzero(c, wide_random());
        end
        settle();
        src_gaps_on = 1'b1;
    endtask

    // Result side: random runs of ready and stall, steady ready when stalls are off, or a long hold-off on request.
    initial begin : result_sink
        bit accepting;
        int run_left;
        accepting = 1'b1;
        run_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_ready <= 1'b0;
            end else if (!sink_stalls_on) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    accepting = !accepting;
                    run_left  = accepting ? $urandom_range(16, 1) : $urandom_range(7, 1);
                end
                run_left--;
                m_ready <= accepting;
            end
        end
    end

    // A word seen with valid and ready at the falling edge is taken at the next rising one.
    always @(negedge aclk) begin : position_check
        matrix_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_entries.size() == 0) begin
                mismatches++;
                $display("%0t: word with nothing expected, row_index %0d column_index %0d",
                         $time, m_row_index, m_column_index);
            end else begin
                want = expected_entries.pop_front();
                if (m_row_index !== want.row) begin
                    mismatches++;
                    $display("%0t: row_index expected %0d, got %0d",
                             $time, want.row, m_row_index);
                end
                if (m_column_index !== want.col) begin
                    mismatches++;
                    $display("%0t: column_index expected %0d, got %0d",
                             $time, want.col, m_column_index);
                end
                if (m_payload_out !== want.payload) begin
                    mismatches++;
                    $display("%0t: payload_out expected %h, got %h",
                             $time, want.payload, m_payload_out);
                end
                if (m_bad_coord !== want.bad) begin
                    mismatches++;
                    $display("%0t: bad_coord expected %0d, got %0d",
                             $time, want.bad, m_bad_coord);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tensor_mode_unfold_index_unit: mismatch");
            $finish;
        end
    end

    initial begin
        shape_modes  = tmu_pkg::RST_NUM_MODES;
        shape_unfold = tmu_pkg::RST_UNFOLD_MODE;
        for (int m = 0; m < tmu_pkg::NUM_DIM_REGS; m++) shape_dim[m] = tmu_pkg::RST_DIM;
        rebuild_strides();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_coordinate_extremes();
        test_mode_count_limits();
        test_unfold_out_of_range();
        test_zero_size();
        test_output_backpressure();
        test_random_traffic();

        settle();
        repeat (2 * MODES) @(posedge aclk);
        if (expected_entries.size() != 0) begin
            mismatches++;
            $display("%0t: %0d words never returned", $time, expected_entries.size());
        end
        if (mismatches == 0) begin
            $display("tensor_mode_unfold_index_unit: match");
        end else begin
            $display("tensor_mode_unfold_index_unit: mismatch");
        end
        $finish;
    end

endmodule
